// ===== hdl/mpeca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeca_pkg
// Shared types and constants of the MPE member-channel allocator.
// ----------------------------------------------------------------------------
package mpeca_pkg;

  localparam int MEMBER_CHANNELS = 15;
  localparam int EVICT_DEPTH     = 16;

  localparam int ChIdxW  = $clog2(MEMBER_CHANNELS);
  localparam int EvIdxW  = (EVICT_DEPTH > 1) ? $clog2(EVICT_DEPTH) : 1;
  localparam int ChanW   = 4;
  localparam int AgeW    = 4;
  localparam int IdW     = 32;
  localparam int PitchW  = 7;
  localparam int FracW   = 12;
  localparam int OffW    = 12;
  localparam int BendW   = 14;
  localparam int Bend7W  = 7;

  localparam logic [AgeW-1:0] AGE_MAX     = 4'd15;
  localparam int              BEND_CENTRE = 8192;
  localparam int              BEND_MAX    = 16383;

  // request codes
  localparam logic REQ_NOTE_ON  = 1'b0;
  localparam logic REQ_NOTE_OFF = 1'b1;

  // event kinds on the result port
  localparam logic [1:0] KIND_ON   = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_BEND = 2'd2;

  typedef enum logic [1:0] {
    CH_NOP,
    CH_FREE,
    CH_TAKE
  } chan_op_e;

  typedef enum logic [1:0] {
    EV_NOP,
    EV_CLEAR,
    EV_RECORD
  } ev_op_e;

  typedef struct packed {
    logic                     req_type;
    logic signed [IdW-1:0]    note_id;
    logic        [PitchW-1:0] pitch_base;
    logic        [FracW-1:0]  pitch_fraction;
    logic        [OffW-1:0]   sample_offset;
  } req_t;

  typedef struct packed {
    logic        [1:0]        event_kind;
    logic        [ChanW-1:0]  channel;
    logic        [PitchW-1:0] out_pitch;
    logic signed [IdW-1:0]    out_note_id;
    logic        [OffW-1:0]   out_offset;
    logic        [Bend7W-1:0] bend_low;
    logic        [Bend7W-1:0] bend_high;
    logic                     last_of_run;
  } res_t;

  // search word travelling along the channel chain
  typedef struct packed {
    logic              live;
    logic [IdW-1:0]    id;
    logic [ChIdxW-1:0] start;
    logic              hit;
    logic [ChIdxW-1:0] hit_idx;
    logic [AgeW-1:0]   hit_age;
    logic              free_ge;
    logic [ChIdxW-1:0] free_ge_idx;
    logic              free_any;
    logic [ChIdxW-1:0] free_any_idx;
    logic              old_set;
    logic [ChIdxW-1:0] old_idx;
    logic [AgeW-1:0]   old_age;
    logic [IdW-1:0]    old_owner;
  } chan_sweep_t;

  typedef struct packed {
    chan_op_e          op;
    logic [ChIdxW-1:0] idx;
    logic [AgeW-1:0]   age_ref;
    logic [IdW-1:0]    id;
  } chan_cmd_t;

  // search word travelling along the evicted-note chain
  typedef struct packed {
    logic              live;
    logic [IdW-1:0]    id;
    logic              hit;
    logic [EvIdxW-1:0] hit_idx;
    logic [ChanW-1:0]  hit_ch;
  } ev_sweep_t;

  typedef struct packed {
    ev_op_e            op;
    logic [EvIdxW-1:0] idx;
    logic [IdW-1:0]    owner;
    logic [ChanW-1:0]  ch;
  } ev_cmd_t;

endpackage

// ===== hdl/mpeca_chan_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeca_chan_cell
// One member channel: busy flag, owner id and age rank, plus one stage of
// the search chain.
// ----------------------------------------------------------------------------
module mpeca_chan_cell
  import mpeca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ChIdxW-1:0] idx_i,
  input  chan_sweep_t       sweep_i,
  output chan_sweep_t       sweep_o,
  input  chan_cmd_t         cmd_i
);

  logic            busy_q;
  logic [AgeW-1:0] age_q;
  logic [IdW-1:0]  owner_q;
  logic            live_q;
  chan_sweep_t     sweep_d, sweep_q;
  logic            me;

  assign me = (cmd_i.idx == idx_i);

  always_comb begin
    sweep_d = sweep_i;
    if (!sweep_i.hit && busy_q && (owner_q == sweep_i.id)) begin
      sweep_d.hit     = 1'b1;
      sweep_d.hit_idx = idx_i;
      sweep_d.hit_age = age_q;
    end
    if (!sweep_i.free_ge && !busy_q && (idx_i >= sweep_i.start)) begin
      sweep_d.free_ge     = 1'b1;
      sweep_d.free_ge_idx = idx_i;
    end
    if (!sweep_i.free_any && !busy_q) begin
      sweep_d.free_any     = 1'b1;
      sweep_d.free_any_idx = idx_i;
    end
    // first greatest age wins
    if (!sweep_i.old_set || (age_q > sweep_i.old_age)) begin
      sweep_d.old_set   = 1'b1;
      sweep_d.old_idx   = idx_i;
      sweep_d.old_age   = age_q;
      sweep_d.old_owner = owner_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= sweep_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    sweep_q <= sweep_d;
  end

  always_comb begin
    sweep_o      = sweep_q;
    sweep_o.live = live_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      age_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        CH_FREE: begin
          if (me) begin
            busy_q <= 1'b0;
            age_q  <= '0;
          end else if (busy_q && (age_q > cmd_i.age_ref)) begin
            age_q <= age_q - AgeW'(1);
          end
        end
        CH_TAKE: begin
          if (me) begin
            busy_q <= 1'b1;
            age_q  <= '0;
          end else if (busy_q && (age_q < AGE_MAX)) begin
            age_q <= age_q + AgeW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == CH_TAKE) && me) begin
      owner_q <= cmd_i.id;
    end
  end

endmodule

// ===== hdl/mpeca_evict_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeca_evict_cell
// One entry of the evicted-note table plus one stage of its search chain.
// ----------------------------------------------------------------------------
module mpeca_evict_cell
  import mpeca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [EvIdxW-1:0] idx_i,
  input  ev_sweep_t         sweep_i,
  output ev_sweep_t         sweep_o,
  input  ev_cmd_t           cmd_i
);

  logic             valid_q;
  logic [IdW-1:0]   owner_q;
  logic [ChanW-1:0] ch_q;
  logic             live_q;
  ev_sweep_t        sweep_d, sweep_q;
  logic             me;

  assign me = (cmd_i.idx == idx_i);

  always_comb begin
    sweep_d = sweep_i;
    if (!sweep_i.hit && valid_q && (owner_q == sweep_i.id)) begin
      sweep_d.hit     = 1'b1;
      sweep_d.hit_idx = idx_i;
      sweep_d.hit_ch  = ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= sweep_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    sweep_q <= sweep_d;
  end

  always_comb begin
    sweep_o      = sweep_q;
    sweep_o.live = live_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        EV_CLEAR: begin
          if (me) begin
            valid_q <= 1'b0;
          end
        end
        EV_RECORD: begin
          // stale record of the same id is dropped, the slot under the
          // write pointer takes the new one
          if (me) begin
            valid_q <= 1'b1;
          end else if (valid_q && (owner_q == cmd_i.owner)) begin
            valid_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == EV_RECORD) && me) begin
      owner_q <= cmd_i.owner;
      ch_q    <= cmd_i.ch;
    end
  end

endmodule

// ===== hdl/mpe_channel_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_channel_allocator_core
// MPE member-channel allocator: round-robin free-channel search, eviction of
// the oldest note when all channels are taken, and a bounded evicted table.
// ----------------------------------------------------------------------------
// A search word runs along the cell chains, one cell per cycle.
//   Note-on: after the sweep come S_RESOLVE (and S_TAKE with an eviction), S_BEND, S_ON.
//   Note-off: both chains are swept, then the word comes out as busy drops.
// The chain length sets the pace; no new event is taken while busy.
// Reset: channels free, evicted table empty, next channel 1; receiver cannot stall.
module mpe_channel_allocator_core
  import mpeca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SWEEP   = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_TAKE    = 3'd3;
  localparam logic [2:0] S_BEND    = 3'd4;
  localparam logic [2:0] S_ON      = 3'd5;

  logic [2:0]        state_q, state_d;
  req_t              req_q;
  logic [ChanW-1:0]  nxt_ch_q, nxt_ch_d;
  logic [EvIdxW-1:0] ev_ptr_q, ev_ptr_d;
  logic              ch_done_q, ch_done_d;
  logic              ev_done_q, ev_done_d;
  chan_sweep_t       ch_res_q;
  ev_sweep_t         ev_res_q;
  logic [ChanW-1:0]  sel_ch_q, sel_ch_d;
  logic [ChIdxW-1:0] sel_idx_q, sel_idx_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              accept;
  logic [ChanW-1:0]  rr_ch;
  logic [ChIdxW-1:0] rr_start;
  logic [ChIdxW-1:0] free_idx;
  logic [BendW:0]    bend_sum;
  logic [BendW-1:0]  bend_val;

  chan_sweep_t ch_link [MEMBER_CHANNELS+1];
  ev_sweep_t   ev_link [EVICT_DEPTH+1];
  chan_cmd_t   ch_cmd;
  ev_cmd_t     ev_cmd;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // round-robin start; an out-of-range pointer counts as channel 1
  assign rr_ch    = ((nxt_ch_q == '0) || (nxt_ch_q > ChanW'(MEMBER_CHANNELS)))
                    ? ChanW'(1) : nxt_ch_q;
  assign rr_start = ChIdxW'(rr_ch - ChanW'(1));

  // launch words enter cell 0 straight from the request port
  always_comb begin
    ch_link[0]       = '0;
    ch_link[0].live  = accept;
    ch_link[0].id    = req_i.note_id;
    ch_link[0].start = rr_start;
    ev_link[0]       = '0;
    ev_link[0].live  = accept && (req_i.req_type == REQ_NOTE_OFF);
    ev_link[0].id    = req_i.note_id;
  end

  for (genvar i = 0; i < MEMBER_CHANNELS; i++) begin : g_chan
    mpeca_chan_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (ChIdxW'(i)),
      .sweep_i (ch_link[i]),
      .sweep_o (ch_link[i+1]),
      .cmd_i   (ch_cmd)
    );
  end

  for (genvar j = 0; j < EVICT_DEPTH; j++) begin : g_evict
    mpeca_evict_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (EvIdxW'(j)),
      .sweep_i (ev_link[j]),
      .sweep_o (ev_link[j+1]),
      .cmd_i   (ev_cmd)
    );
  end

  // prefer the first free channel at or after the pointer, else wrap
  assign free_idx = ch_res_q.free_ge ? ch_res_q.free_ge_idx : ch_res_q.free_any_idx;

  // bend = centre + Q0.12 fraction, clamped to 14 bits
  assign bend_sum = (BendW+1)'(BEND_CENTRE) + (BendW+1)'(req_q.pitch_fraction);
  assign bend_val = (bend_sum > (BendW+1)'(BEND_MAX)) ? BendW'(BEND_MAX)
                                                      : bend_sum[BendW-1:0];

  always_comb begin
    ch_done_d = ch_done_q;
    ev_done_d = ev_done_q;
    if (accept) begin
      ch_done_d = 1'b0;
      ev_done_d = 1'b0;
    end else begin
      if (ch_link[MEMBER_CHANNELS].live) ch_done_d = 1'b1;
      if (ev_link[EVICT_DEPTH].live)     ev_done_d = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    nxt_ch_d    = nxt_ch_q;
    ev_ptr_d    = ev_ptr_q;
    sel_ch_d    = sel_ch_q;
    sel_idx_d   = sel_idx_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    ch_cmd      = '{op: CH_NOP, idx: '0, age_ref: '0, id: req_q.note_id};
    ev_cmd      = '{op: EV_NOP, idx: ev_ptr_q, owner: ch_res_q.old_owner,
                    ch: ChanW'(ch_res_q.old_idx) + ChanW'(1)};

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SWEEP;
      end

      S_SWEEP: begin
        if (ch_done_q && ((req_q.req_type == REQ_NOTE_ON) || ev_done_q)) begin
          state_d = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        if (req_q.req_type == REQ_NOTE_ON) begin
          priority if (ch_res_q.hit) begin
            // held channel reused, nothing else moves
            sel_ch_d = ChanW'(ch_res_q.hit_idx) + ChanW'(1);
            state_d  = S_BEND;
          end else if (ch_res_q.free_any) begin
            ch_cmd.op  = CH_TAKE;
            ch_cmd.idx = free_idx;
            sel_ch_d   = ChanW'(free_idx) + ChanW'(1);
            nxt_ch_d   = (free_idx == ChIdxW'(MEMBER_CHANNELS - 1))
                         ? ChanW'(1) : ChanW'(free_idx) + ChanW'(2);
            state_d    = S_BEND;
          end else begin
            // all busy: drop the oldest, log it, tell the synth to stop it
            ch_cmd.op      = CH_FREE;
            ch_cmd.idx     = ch_res_q.old_idx;
            ch_cmd.age_ref = ch_res_q.old_age;
            ev_cmd.op      = EV_RECORD;
            ev_ptr_d       = (ev_ptr_q == EvIdxW'(EVICT_DEPTH - 1))
                             ? '0 : ev_ptr_q + EvIdxW'(1);
            sel_idx_d      = ch_res_q.old_idx;
            sel_ch_d       = ChanW'(ch_res_q.old_idx) + ChanW'(1);
            res_valid_d       = 1'b1;
            res_d.event_kind  = KIND_OFF;
            res_d.channel     = ChanW'(ch_res_q.old_idx) + ChanW'(1);
            res_d.out_note_id = ch_res_q.old_owner;
            state_d           = S_TAKE;
          end
        end else begin
          priority if (ch_res_q.hit) begin
            ch_cmd.op      = CH_FREE;
            ch_cmd.idx     = ch_res_q.hit_idx;
            ch_cmd.age_ref = ch_res_q.hit_age;
            res_valid_d       = 1'b1;
            res_d.event_kind  = KIND_OFF;
            res_d.channel     = ChanW'(ch_res_q.hit_idx) + ChanW'(1);
            res_d.out_pitch   = req_q.pitch_base;
            res_d.out_note_id = req_q.note_id;
            res_d.out_offset  = req_q.sample_offset;
            res_d.last_of_run = 1'b1;
          end else if (ev_res_q.hit) begin
            ev_cmd.op         = EV_CLEAR;
            ev_cmd.idx        = ev_res_q.hit_idx;
            res_valid_d       = 1'b1;
            res_d.event_kind  = KIND_OFF;
            res_d.channel     = ev_res_q.hit_ch;
            res_d.out_pitch   = req_q.pitch_base;
            res_d.out_note_id = req_q.note_id;
            res_d.out_offset  = req_q.sample_offset;
            res_d.last_of_run = 1'b1;
          end else begin
            // unknown id: silent
          end
          state_d = S_IDLE;
        end
      end

      S_TAKE: begin
        ch_cmd.op  = CH_TAKE;
        ch_cmd.idx = sel_idx_q;
        nxt_ch_d   = (sel_idx_q == ChIdxW'(MEMBER_CHANNELS - 1))
                     ? ChanW'(1) : ChanW'(sel_idx_q) + ChanW'(2);
        state_d    = S_BEND;
      end

      S_BEND: begin
        res_valid_d      = 1'b1;
        res_d.event_kind = KIND_BEND;
        res_d.channel    = sel_ch_q;
        res_d.out_offset = req_q.sample_offset;
        res_d.bend_low   = bend_val[Bend7W-1:0];
        res_d.bend_high  = bend_val[BendW-1:Bend7W];
        state_d          = S_ON;
      end

      S_ON: begin
        res_valid_d       = 1'b1;
        res_d.event_kind  = KIND_ON;
        res_d.channel     = sel_ch_q;
        res_d.out_pitch   = req_q.pitch_base;
        res_d.out_note_id = req_q.note_id;
        res_d.out_offset  = req_q.sample_offset;
        res_d.last_of_run = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nxt_ch_q    <= ChanW'(1);
      ev_ptr_q    <= '0;
      ch_done_q   <= 1'b0;
      ev_done_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_ch_q    <= nxt_ch_d;
      ev_ptr_q    <= ev_ptr_d;
      ch_done_q   <= ch_done_d;
      ev_done_q   <= ev_done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (ch_link[MEMBER_CHANNELS].live) ch_res_q <= ch_link[MEMBER_CHANNELS];
    if (ev_link[EVICT_DEPTH].live)     ev_res_q <= ev_link[EVICT_DEPTH];
    sel_ch_q  <= sel_ch_d;
    sel_idx_q <= sel_idx_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // words only come out of work started by an accepted event
  a_word_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result word without an event in progress");

  // the final word of an event releases the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_of_run) |-> !busy)
    else $error("block still busy after final word");

  // a pitch bend is always followed by its note-on on the same channel
  a_bend_then_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_kind == KIND_BEND)) |=>
      (res_valid_o && (res_o.event_kind == KIND_ON) &&
       (res_o.channel == $past(res_o.channel))))
    else $error("pitch bend not followed by matching note-on");

  // every bend and note-on word names a real member channel
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_kind != KIND_OFF)) |->
      ((res_o.channel != '0) && (res_o.channel <= ChanW'(MEMBER_CHANNELS))))
    else $error("result on a channel outside the member range");

endmodule
